/* src/bma_pkg.sv */
`default_nettype none
package bma_pkg;

  localparam int POOL_ORDER = 16;
  localparam int MIN_ORDER  = 4;
  localparam int LEVELS     = POOL_ORDER - MIN_ORDER;
  localparam int SLOT_COUNT = 1 << LEVELS;
  localparam int NODE_COUNT = (2 << LEVELS) - 1;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SLOT_W     = LEVELS;
  localparam int MASK_W     = LEVELS + 1;
  localparam int BIT_W      = $clog2(MASK_W);
  localparam int ORD_W      = 5;
  localparam int ADDR_W     = POOL_ORDER;

  localparam logic       CMD_ALLOC  = 1'b0;
  localparam logic       CMD_FREE   = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef logic [MASK_W-1:0] mask_t;

  typedef struct packed {
    logic        command;
    logic [15:0] request_size;
    logic [15:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_offset;
    logic [4:0]  granted_order;
  } rsp_t;

  // bit per order present in a subtree, bit 0 is the smallest block
  function automatic mask_t bit_of(input logic [ORD_W-1:0] ord);
    return mask_t'(1) << (ord - ORD_W'(MIN_ORDER));
  endfunction

  function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] ord,
                                                input logic [ADDR_W-1:0] addr);
    logic [31:0] b;
    b = ((32'd1 << (POOL_ORDER - 32'(ord))) - 32'd1) + (32'(addr) >> ord);
    return b[NODE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* src/bma_ram.sv */
`default_nettype none
module bma_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/bma_ctrl.sv */
`default_nettype none
module bma_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire bma_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output bma_pkg::rsp_t       rsp,
  output logic                m_we,
  output logic [bma_pkg::NODE_W-1:0] m_waddr,
  output bma_pkg::mask_t      m_wdata,
  output logic [bma_pkg::NODE_W-1:0] m_raddr,
  input  wire bma_pkg::mask_t m_rdata,
  output logic                o_we,
  output logic [bma_pkg::SLOT_W-1:0] o_waddr,
  output logic [bma_pkg::ORD_W-1:0]  o_wdata,
  output logic [bma_pkg::SLOT_W-1:0] o_raddr,
  input  wire logic [bma_pkg::ORD_W-1:0] o_rdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_PICK, S_A_DN, S_A_DNW, S_A_FOUND,
    S_F_CHK, S_F_RD, S_F_DEC, S_F_SET, S_UP_RD, S_UP_WR, S_DONE
  } state_t;

  state_t state;
  logic [bma_pkg::NODE_W-1:0] clr;
  logic [bma_pkg::NODE_W-1:0] node;
  logic [bma_pkg::ORD_W-1:0]  level;
  logic [bma_pkg::ORD_W-1:0]  want;
  logic [bma_pkg::ORD_W-1:0]  k;
  logic [bma_pkg::ORD_W-1:0]  split_top;
  logic [bma_pkg::ADDR_W-1:0] addr;
  logic [15:0]                req_off;
  bma_pkg::mask_t             cur_mask;
  logic                       forced;
  bma_pkg::rsp_t              res;

  logic [bma_pkg::NODE_W-1:0] sib;
  logic [bma_pkg::NODE_W-1:0] parent;
  logic [bma_pkg::NODE_W-1:0] left;
  bma_pkg::mask_t             pm;
  bma_pkg::mask_t             sel;
  logic [bma_pkg::ORD_W-1:0]  want_in;
  logic [bma_pkg::ORD_W-1:0]  k_sel;
  logic [bma_pkg::ADDR_W-1:0] addr_dn;
  logic                       free_ok;
  logic [bma_pkg::BIT_W-1:0]  k_bit;
  logic [bma_pkg::BIT_W-1:0]  lvl_bit;

  function automatic logic [bma_pkg::ORD_W-1:0] want_of(input logic [15:0] size);
    logic [bma_pkg::ORD_W-1:0] w;
    w = bma_pkg::ORD_W'(bma_pkg::MIN_ORDER);
    for (int o = bma_pkg::MIN_ORDER; o <= bma_pkg::POOL_ORDER; o++) begin
      if (32'(size) > (32'd1 << o)) begin
        w = bma_pkg::ORD_W'(o + 1);
      end
    end
    return w;
  endfunction

  always_comb begin
    k_bit   = bma_pkg::BIT_W'(k - bma_pkg::ORD_W'(bma_pkg::MIN_ORDER));
    lvl_bit = bma_pkg::BIT_W'(level - bma_pkg::ORD_W'(bma_pkg::MIN_ORDER));
    sib     = node[0] ? node + 1'b1 : node - 1'b1;
    parent  = (node - 1'b1) >> 1;
    left    = {node[bma_pkg::NODE_W-2:0], 1'b1};
    pm      = cur_mask | (forced ? bma_pkg::bit_of(level) : m_rdata);
    want_in = want_of(req.request_size);
    sel     = m_rdata & ~(bma_pkg::bit_of(want) - bma_pkg::mask_t'(1));
    k_sel   = '0;
    for (int i = bma_pkg::LEVELS; i >= 0; i--) begin
      if (sel[i]) begin
        k_sel = bma_pkg::ORD_W'(i + bma_pkg::MIN_ORDER);
      end
    end
    addr_dn = m_rdata[k_bit] ? addr
            : addr | (bma_pkg::ADDR_W'(1) << (level - 1'b1));
    free_ok = (req_off[bma_pkg::MIN_ORDER-1:0] == '0)
            && ((32'(req_off) >> bma_pkg::POOL_ORDER) == 32'd0)
            && (o_rdata >= bma_pkg::ORD_W'(bma_pkg::MIN_ORDER))
            && (o_rdata <= bma_pkg::ORD_W'(bma_pkg::POOL_ORDER));
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = node;
    m_wdata = '0;
    m_raddr = node;
    o_we    = 1'b0;
    o_waddr = bma_pkg::SLOT_W'(req_off >> bma_pkg::MIN_ORDER);
    o_wdata = '0;
    o_raddr = bma_pkg::SLOT_W'(req.block_offset >> bma_pkg::MIN_ORDER);
    case (state)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr;
        m_wdata = (clr == '0) ? bma_pkg::bit_of(bma_pkg::ORD_W'(bma_pkg::POOL_ORDER)) : '0;
        o_we    = 32'(clr) < bma_pkg::SLOT_COUNT;
        o_waddr = clr[bma_pkg::SLOT_W-1:0];
      end
      S_IDLE:  m_raddr = '0;
      S_A_DN:  m_raddr = left;
      S_A_FOUND: begin
        m_we    = 1'b1;
        o_we    = 1'b1;
        o_waddr = bma_pkg::SLOT_W'(addr >> bma_pkg::MIN_ORDER);
        o_wdata = want;
      end
      S_F_CHK: o_we = free_ok;
      S_F_RD: begin
        m_we    = 1'b1;
        m_raddr = sib;
      end
      S_F_DEC: begin
        m_we    = m_rdata[lvl_bit];
        m_waddr = sib;
      end
      S_F_SET: begin
        m_we    = 1'b1;
        m_wdata = bma_pkg::bit_of(level);
      end
      S_UP_RD: begin
        m_we    = level < split_top;
        m_waddr = sib;
        m_wdata = bma_pkg::bit_of(level);
        m_raddr = sib;
      end
      S_UP_WR: begin
        m_we    = 1'b1;
        m_waddr = parent;
        m_wdata = pm;
      end
      default: ;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == bma_pkg::NODE_COUNT - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_off <= req.block_offset;
            want    <= want_in;
            if (req.command == bma_pkg::CMD_FREE) begin
              state <= S_F_CHK;
            end else if (want_in > bma_pkg::ORD_W'(bma_pkg::POOL_ORDER)) begin
              res   <= '{bma_pkg::ST_NOFIT, 16'd0, 5'd0};
              state <= S_DONE;
            end else begin
              state <= S_A_PICK;
            end
          end
        end
        S_A_PICK: begin
          k         <= k_sel;
          split_top <= k_sel;
          addr      <= '0;
          if (sel == '0) begin
            res   <= '{bma_pkg::ST_NOFIT, 16'd0, 5'd0};
            state <= S_DONE;
          end else if (k_sel == bma_pkg::ORD_W'(bma_pkg::POOL_ORDER)) begin
            node  <= bma_pkg::node_of(want, '0);
            level <= want;
            state <= S_A_FOUND;
          end else begin
            node  <= '0;
            level <= bma_pkg::ORD_W'(bma_pkg::POOL_ORDER);
            state <= S_A_DN;
          end
        end
        S_A_DN: state <= S_A_DNW;
        S_A_DNW: begin
          addr <= addr_dn;
          if (level - 1'b1 == k) begin
            node  <= bma_pkg::node_of(want, addr_dn);
            level <= want;
            state <= S_A_FOUND;
          end else begin
            node  <= m_rdata[k_bit] ? left : left + 1'b1;
            level <= level - 1'b1;
            state <= S_A_DN;
          end
        end
        S_A_FOUND: begin
          cur_mask <= '0;
          res      <= '{bma_pkg::ST_OK, 16'(addr), want};
          state    <= (want == bma_pkg::ORD_W'(bma_pkg::POOL_ORDER)) ? S_DONE : S_UP_RD;
        end
        S_F_CHK: begin
          if (!free_ok) begin
            res   <= '{bma_pkg::ST_BADFREE, 16'd0, 5'd0};
            state <= S_DONE;
          end else begin
            res   <= '{bma_pkg::ST_OK, 16'd0, o_rdata};
            level <= o_rdata;
            addr  <= bma_pkg::ADDR_W'(req_off);
            node  <= bma_pkg::node_of(o_rdata, bma_pkg::ADDR_W'(req_off));
            state <= (o_rdata == bma_pkg::ORD_W'(bma_pkg::POOL_ORDER)) ? S_F_SET : S_F_RD;
          end
        end
        S_F_RD: state <= S_F_DEC;
        S_F_DEC: begin
          if (m_rdata[lvl_bit]) begin
            node  <= parent;
            addr  <= addr & ~(bma_pkg::ADDR_W'(1) << level);
            level <= level + 1'b1;
            state <= (level + 1'b1 == bma_pkg::ORD_W'(bma_pkg::POOL_ORDER)) ? S_F_SET : S_F_RD;
          end else begin
            state <= S_F_SET;
          end
        end
        S_F_SET: begin
          cur_mask  <= bma_pkg::bit_of(level);
          split_top <= level;
          state     <= (level == bma_pkg::ORD_W'(bma_pkg::POOL_ORDER)) ? S_DONE : S_UP_RD;
        end
        S_UP_RD: begin
          forced <= level < split_top;
          state  <= S_UP_WR;
        end
        S_UP_WR: begin
          cur_mask <= pm;
          node     <= parent;
          level    <= level + 1'b1;
          state    <= (level + 1'b1 == bma_pkg::ORD_W'(bma_pkg::POOL_ORDER)) ? S_DONE : S_UP_RD;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/buddy_memory_allocator_unit.sv */
`default_nettype none
// Allocation walks the tree down to the chosen block and back up; a free walks it up; a result
// may also wait for rsp_ready on an earlier result.
// One transaction at a time; a new one can be accepted as soon as rsp_valid rises;
// a finished result waits in the output register while the next one is served.
// Reset: a clearing pass over all 8191 tree nodes rewrites the node-mask and order memories;
// req_ready stays low until it ends.
module buddy_memory_allocator_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bma_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output bma_pkg::rsp_t      rsp
);

  logic                              m_we;
  logic [bma_pkg::NODE_W-1:0]        m_waddr;
  bma_pkg::mask_t                    m_wdata;
  logic [bma_pkg::NODE_W-1:0]        m_raddr;
  bma_pkg::mask_t                    m_rdata;
  logic                              o_we;
  logic [bma_pkg::SLOT_W-1:0]        o_waddr;
  logic [bma_pkg::ORD_W-1:0]         o_wdata;
  logic [bma_pkg::SLOT_W-1:0]        o_raddr;
  logic [bma_pkg::ORD_W-1:0]         o_rdata;

  bma_ram #(.DEPTH(bma_pkg::NODE_COUNT), .WIDTH(bma_pkg::MASK_W)) u_mask (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  bma_ram #(.DEPTH(bma_pkg::SLOT_COUNT), .WIDTH(bma_pkg::ORD_W)) u_order (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  bma_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .m_we(m_we), .m_waddr(m_waddr), .m_wdata(m_wdata),
    .m_raddr(m_raddr), .m_rdata(m_rdata),
    .o_we(o_we), .o_waddr(o_waddr), .o_wdata(o_wdata),
    .o_raddr(o_raddr), .o_rdata(o_rdata)
  );

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("accepting during clearing pass");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second transaction accepted while busy");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != bma_pkg::ST_OK |-> rsp.granted_offset == 16'd0
      && rsp.granted_order == 5'd0)
    else $error("failed transaction carries data");
  a_order_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == bma_pkg::ST_OK
      |-> rsp.granted_order >= 5'(bma_pkg::MIN_ORDER)
      && rsp.granted_order <= 5'(bma_pkg::POOL_ORDER))
    else $error("granted order out of range");
`endif

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  bma_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  bma_pkg::rsp_t rsp;

  buddy_memory_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // allocator shadow state
  bit node_free [bma_pkg::NODE_COUNT];
  bit [4:0] slot_order [bma_pkg::SLOT_COUNT];

  bma_pkg::req_t pending_reqs[$];
  bma_pkg::rsp_t expected_rsps[$];
  int unsigned live[$];
  int errors = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic int node_idx(int ord, int unsigned offs);
    return ((1 << (bma_pkg::POOL_ORDER - ord)) - 1) + (offs >> ord);
  endfunction

  function automatic bma_pkg::rsp_t serve_request(bma_pkg::req_t r);
    bma_pkg::rsp_t o;
    int want, k, i, cnt, slot, ord, addr, buddy;
    int unsigned offs;
    bit found;
    o = '0;
    found = 1'b0;
    offs = 0;
    if (r.command == bma_pkg::CMD_ALLOC) begin
      want = bma_pkg::MIN_ORDER;
      while (want <= bma_pkg::POOL_ORDER && (1 << want) < int'(r.request_size)) want++;
      if (want > bma_pkg::POOL_ORDER) begin
        o.status = bma_pkg::ST_NOFIT;
        return o;
      end
      for (k = want; k <= bma_pkg::POOL_ORDER; k++) begin
        cnt = 1 << (bma_pkg::POOL_ORDER - k);
        for (i = 0; i < cnt; i++) begin
          if (node_free[cnt - 1 + i]) begin
            offs = i << k;
            node_free[cnt - 1 + i] = 1'b0;
            found = 1'b1;
            break;
          end
        end
        if (found) break;
      end
      if (!found) begin
        o.status = bma_pkg::ST_NOFIT;
        return o;
      end
      while (k > want) begin
        k--;
        node_free[node_idx(k, offs + (1 << k))] = 1'b1;
      end
      slot_order[(offs >> bma_pkg::MIN_ORDER) % bma_pkg::SLOT_COUNT] = want[4:0];
      o.status = bma_pkg::ST_OK;
      o.granted_offset = offs[15:0];
      o.granted_order = want[4:0];
    end else begin
      offs = r.block_offset;
      slot = offs >> bma_pkg::MIN_ORDER;
      if ((offs % (1 << bma_pkg::MIN_ORDER)) != 0 || slot >= bma_pkg::SLOT_COUNT
          || slot_order[slot] == 0) begin
        o.status = bma_pkg::ST_BADFREE;
        return o;
      end
      ord = slot_order[slot];
      slot_order[slot] = '0;
      k = ord;
      addr = offs;
      while (k < bma_pkg::POOL_ORDER) begin
        buddy = addr ^ (1 << k);
        if (!node_free[node_idx(k, buddy)]) break;
        node_free[node_idx(k, buddy)] = 1'b0;
        addr = addr & ~(1 << k);
        k++;
      end
      node_free[node_idx(k, addr)] = 1'b1;
      o.status = bma_pkg::ST_OK;
      o.granted_order = ord[4:0];
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bma_pkg::req_t make_alloc(int sz);
    bma_pkg::req_t r;
    r = '0;
    r.command = bma_pkg::CMD_ALLOC;
    r.request_size = sz[15:0];
    r.block_offset = 16'($urandom);
    return r;
  endfunction

  function automatic bma_pkg::req_t make_free(int offs);
    bma_pkg::req_t r;
    r = '0;
    r.command = bma_pkg::CMD_FREE;
    r.request_size = 16'($urandom);
    r.block_offset = offs[15:0];
    return r;
  endfunction

  // queue a transaction with its predicted result; granted blocks become free candidates
  task automatic add_item(bma_pkg::req_t r);
    bma_pkg::rsp_t e;
    e = serve_request(r);
    pending_reqs.push_back(r);
    expected_rsps.push_back(e);
    if (r.command == bma_pkg::CMD_ALLOC && e.status == bma_pkg::ST_OK)
      live.push_back(e.granted_offset);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      in_gap = pick_gap();
      if (in_gap == 0 && pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end else if (!req_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    bma_pkg::rsp_t e;
    cycles++;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status)
            report_mismatch("status", rsp.status, e.status);
          if (rsp.granted_offset !== e.granted_offset)
            report_mismatch("granted_offset", rsp.granted_offset, e.granted_offset);
          if (rsp.granted_order !== e.granted_order)
            report_mismatch("granted_order", rsp.granted_order, e.granted_order);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        rsp_ready <= 1'b0;
      end else begin
        out_gap = pick_gap();
        rsp_ready <= (out_gap == 0);
      end
    end
  end

  initial begin : stim
    int n, sz, o, idx;
    for (int i = 0; i < bma_pkg::NODE_COUNT; i++) node_free[i] = 1'b0;
    for (int i = 0; i < bma_pkg::SLOT_COUNT; i++) slot_order[i] = '0;
    node_free[0] = 1'b1;

    // directed
    add_item(make_alloc(0));
    add_item(make_alloc(1));
    add_item(make_alloc(16));
    add_item(make_alloc(17));
    add_item(make_alloc(65535));
    add_item(make_free(0));
    add_item(make_free(0));
    add_item(make_free(16));
    add_item(make_free(32));
    add_item(make_free(7));
    add_item(make_free(65535));
    add_item(make_free(65520));
    add_item(make_alloc(65535));
    add_item(make_alloc(1));
    add_item(make_free(0));
    add_item(make_alloc(32768));
    add_item(make_alloc(32769));
    add_item(make_alloc(32768));
    add_item(make_alloc(1));
    add_item(make_free(0));
    add_item(make_free(32768));
    add_item(make_alloc(65535));
    add_item(make_free(0));
    live.delete();

    // random: allocations, frees of granted blocks, and stray frees
    for (n = 0; n < 1950; n++) begin
      o = $urandom_range(0, 99);
      if (o < 50) begin
        case ($urandom_range(0, 5))
          0: sz = $urandom_range(0, 65535);
          1: sz = $urandom_range(0, 16);
          default: sz = $urandom_range(1, 1 << $urandom_range(4, 12));
        endcase
        add_item(make_alloc(sz));
      end else if (o < 90 && live.size() > 0) begin
        idx = $urandom_range(0, live.size() - 1);
        add_item(make_free(live[idx]));
        live.delete(idx);
      end else if (o < 95) begin
        add_item(make_free($urandom_range(0, 65535)));
      end else begin
        add_item(make_free($urandom_range(0, 4095) << 4));
      end
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    wait (stim_done);
    while ((pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
           && cycles < 3000000)
      @(posedge clk);
    if (cycles >= 3000000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      repeat (100) @(posedge clk);
      if (errors == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
      $finish;
    end
  end

endmodule
